FILE: rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

  localparam int unsigned LEN_W     = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [LEN_W-1:0]  CNT_MAX      = 10'd1023;
  localparam logic [LEN_W-1:0]  MIN_MODULUS  = 10'd11;
  localparam logic [LEN_W-1:0]  MIN_PAD      = 10'd8;
  localparam logic [LEN_W-1:0]  MODULUS_RST  = 10'd256;
  localparam logic [LEN_W-1:0]  CAPACITY_RST = 10'd512;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_TYPE = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_PAD  = 8'hff;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_LEN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 4'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_KEYSMALL = 3'd1,
    ST_LEAD     = 3'd2,
    ST_TYPE     = 3'd3,
    ST_BADPAD   = 3'd4,
    ST_NOSEP    = 3'd5,
    ST_SHORTPAD = 3'd6,
    ST_TOOLARGE = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_TYPE    = 5'b00010,
    PH_PAD     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DRAIN   = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

FILE: rtl/pcc_byte_if.sv
`default_nettype none

interface pcc_byte_if
  import pcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  block_len;
  logic              last_byte;

  modport source (output valid, output data_byte, output block_len, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input block_len, input last_byte,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/pcc_res_if.sv
`default_nettype none

interface pcc_res_if
  import pcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              done_res;
  logic [2:0]        status;
  logic [LEN_W-1:0]  payload_len;

  modport source (output valid, output out_byte, output byte_valid, output done_res,
                  output status, output payload_len, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input done_res,
                input status, input payload_len, output ready);
endinterface

`default_nettype wire

FILE: rtl/pcc_cfg_if.sv
`default_nettype none

interface pcc_cfg_if
  import pcc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEN_W-1:0]     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/pkcs1_type1_pad_checker.sv
// PKCS#1 v1.5 type-1 padding checker, one byte of a decrypted block per word.
// byte_in carries data_byte, block_len and last_byte; a word moves when valid
// and ready are both high. res_out gives at most one word per input word: a
// payload byte (byte_valid) and/or, on the block's last byte, done_res with
// the status and payload_len. Header bytes and bytes after an error give no
// output word. cfg writes modulus_len (index 0) and out_capacity (index 1);
// other indexes are ignored, cfg.ready is always high, and writes belong
// between blocks.
// Throughput is one byte per cycle while the receiver takes results. The byte
// is registered, checked against the block state, and its result registered.
// The checker state advances only when the result register can take a word,
// so a receiver stall holds the input register and then drops byte_in.ready;
// nothing is lost. Reset (rst, synchronous) empties both registers, returns
// the state to the start of a block and sets modulus_len 256, out_capacity
// 512. MAX_BLOCK_BYTES bounds the block: a longer one reports toolarge.
`default_nettype none

module pkcs1_type1_pad_checker
  import pcc_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = 512
) (
  input  wire           clk,
  input  wire           rst,
  pcc_byte_if.sink      byte_in,
  pcc_res_if.source     res_out,
  pcc_cfg_if.sink       cfg
);

  localparam logic [LEN_W:0] MAX_IDX = (LEN_W+1)'(MAX_BLOCK_BYTES);

  logic [LEN_W-1:0]  modulus_len;
  logic [LEN_W-1:0]  out_capacity;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [LEN_W-1:0]  s1_len;
  logic              s1_last;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  byte_index, byte_index_next;
  logic [LEN_W-1:0]  pad_count, pad_count_next;
  status_t           error_code, error_code_next;
  logic [LEN_W-1:0]  emitted_count, emitted_count_next;

  logic              res_valid;
  logic [BYTE_W-1:0] res_byte;
  logic              res_bv;
  logic              res_done;
  status_t           res_status;
  logic [LEN_W-1:0]  res_plen;

  logic              out_free;
  logic              proc;
  logic              gives_result;
  logic              emit;
  logic [LEN_W:0]    idx_ext;
  logic [LEN_W:0]    len_ext;
  logic [LEN_W:0]    idx_plus;
  logic [LEN_W:0]    rest;
  status_t           st_final;

  assign out_free      = !res_valid || res_out.ready;
  assign proc          = s1_valid && out_free;
  assign byte_in.ready = !s1_valid || out_free;
  assign cfg.ready     = 1'b1;

  assign idx_ext  = {1'b0, byte_index};
  assign len_ext  = {1'b0, s1_len};
  assign idx_plus = idx_ext + (LEN_W+1)'(1);
  assign rest     = (len_ext > idx_plus) ? (len_ext - idx_plus) : '0;

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    pad_count_next     = pad_count;
    error_code_next    = error_code;
    emitted_count_next = emitted_count;
    emit               = 1'b0;
    st_final           = ST_OK;

    if (phase != PH_DRAIN && idx_ext >= MAX_IDX) begin
      phase_next      = PH_DRAIN;
      error_code_next = ST_TOOLARGE;
    end else begin
      case (phase)
        PH_FIRST: begin
          if (modulus_len < MIN_MODULUS) begin
            phase_next      = PH_DRAIN;
            error_code_next = ST_KEYSMALL;
          end else if (modulus_len == s1_len) begin
            if (s1_byte != BYTE_ZERO) begin
              phase_next      = PH_DRAIN;
              error_code_next = ST_LEAD;
            end else begin
              phase_next = PH_TYPE;
            end
          end else if ({1'b0, modulus_len} != len_ext + (LEN_W+1)'(1)
                       || s1_byte != BYTE_TYPE) begin
            phase_next      = PH_DRAIN;
            error_code_next = ST_TYPE;
          end else begin
            phase_next = PH_PAD;
          end
        end
        PH_TYPE: begin
          if (modulus_len != s1_len || s1_byte != BYTE_TYPE) begin
            phase_next      = PH_DRAIN;
            error_code_next = ST_TYPE;
          end else begin
            phase_next = PH_PAD;
          end
        end
        PH_PAD: begin
          if (s1_byte == BYTE_PAD) begin
            if (pad_count < CNT_MAX) pad_count_next = pad_count + LEN_W'(1);
          end else if (s1_byte == BYTE_ZERO) begin
            if (pad_count < MIN_PAD) begin
              phase_next      = PH_DRAIN;
              error_code_next = ST_SHORTPAD;
            end else if (rest > {1'b0, out_capacity}) begin
              phase_next      = PH_DRAIN;
              error_code_next = ST_TOOLARGE;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            phase_next      = PH_DRAIN;
            error_code_next = ST_BADPAD;
          end
        end
        PH_PAYLOAD: begin
          if (emitted_count >= out_capacity) begin
            phase_next      = PH_DRAIN;
            error_code_next = ST_TOOLARGE;
          end else begin
            emit = 1'b1;
            if (emitted_count < CNT_MAX) emitted_count_next = emitted_count + LEN_W'(1);
          end
        end
        PH_DRAIN: begin
        end
        default: begin
          phase_next = PH_DRAIN;
        end
      endcase
    end

    if (s1_last) begin
      if (phase_next == PH_TYPE || phase_next == PH_FIRST) begin
        st_final = ST_TYPE;
      end else if (phase_next == PH_PAD) begin
        st_final = ST_NOSEP;
      end else begin
        st_final = error_code_next;
      end
    end else if (byte_index < CNT_MAX) begin
      byte_index_next = byte_index + LEN_W'(1);
    end
  end

  assign gives_result = emit || s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_len  <= MODULUS_RST;
      out_capacity <= CAPACITY_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MODULUS_LEN) modulus_len <= cfg.wdata;
      else if (cfg.index == REG_OUT_CAPACITY) out_capacity <= cfg.wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      s1_byte <= byte_in.data_byte;
      s1_len  <= byte_in.block_len;
      s1_last <= byte_in.last_byte;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      byte_index    <= '0;
      pad_count     <= '0;
      error_code    <= ST_OK;
      emitted_count <= '0;
    end else if (proc) begin
      if (s1_last) begin
        phase         <= PH_FIRST;
        byte_index    <= '0;
        pad_count     <= '0;
        error_code    <= ST_OK;
        emitted_count <= '0;
      end else begin
        phase         <= phase_next;
        byte_index    <= byte_index_next;
        pad_count     <= pad_count_next;
        error_code    <= error_code_next;
        emitted_count <= emitted_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc && gives_result) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && gives_result) begin
      res_byte   <= emit ? s1_byte : '0;
      res_bv     <= emit;
      res_done   <= s1_last;
      res_status <= st_final;
      res_plen   <= (s1_last && st_final == ST_OK) ? emitted_count_next : '0;
    end
  end

  assign res_out.valid       = res_valid;
  assign res_out.out_byte    = res_byte;
  assign res_out.byte_valid  = res_bv;
  assign res_out.done_res    = res_done;
  assign res_out.status      = res_status;
  assign res_out.payload_len = res_plen;

  a_drain_has_error: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DRAIN |-> error_code != ST_OK)
    else $error("drain phase without an error code");

  a_last_clears_block: assert property (@(posedge clk) disable iff (rst)
    proc && s1_last |=> phase == PH_FIRST && byte_index == '0 && emitted_count == '0)
    else $error("block state not cleared after last byte");

  a_stalled_byte_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !proc |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("held byte lost during output stall");

  a_payload_needs_ok: assert property (@(posedge clk) disable iff (rst)
    proc && emit |=> res_valid && res_bv && res_status == ST_OK)
    else $error("payload word not registered as ok");

endmodule

`default_nettype wire

FILE: verif/pkcs1_type1_pad_checker_tb.sv
`timescale 1ns / 1ps

module pkcs1_type1_pad_checker_tb;
  import pcc_pkg::*;

  localparam int MAX_BYTES = 512;
  localparam int RUN_LIMIT = 400000;

  typedef logic [BYTE_W-1:0] frame_t[$];

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              done_res;
    status_t           status;
    logic [LEN_W-1:0]  payload_len;
  } unpad_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcc_byte_if byte_if ();
  pcc_res_if  res_if ();
  pcc_cfg_if  cfg_if ();

  pkcs1_type1_pad_checker dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_if),
    .res_out (res_if),
    .cfg     (cfg_if)
  );

  always #4 clk = ~clk;

  // unpadding state as the block should hold it
  phase_t           unpad_phase;
  logic [LEN_W-1:0] unpad_index;
  logic [LEN_W-1:0] unpad_pads;
  status_t          unpad_err;
  logic [LEN_W-1:0] unpad_emitted;
  logic [LEN_W-1:0] modulus_reg;
  logic [LEN_W-1:0] capacity_reg;

  unpad_word_t words_due[$];

  int mismatches  = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void clear_block();
    unpad_phase   = PH_FIRST;
    unpad_index   = '0;
    unpad_pads    = '0;
    unpad_err     = ST_OK;
    unpad_emitted = '0;
  endfunction

  function automatic void flag_error(input status_t code);
    unpad_err   = code;
    unpad_phase = PH_DRAIN;
  endfunction

  task automatic advance_unpad_state(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] bl,
                                     input logic last);
    int          idx;
    int          rest;
    bit          emit;
    unpad_word_t w;
    idx  = int'(unpad_index);
    emit = 1'b0;
    w    = '0;
    if (unpad_phase != PH_DRAIN && idx >= MAX_BYTES) begin
      flag_error(ST_TOOLARGE);
    end else begin
      case (unpad_phase)
        PH_FIRST: begin
          if (modulus_reg < MIN_MODULUS) flag_error(ST_KEYSMALL);
          else if (modulus_reg == bl) begin
            if (b != BYTE_ZERO) flag_error(ST_LEAD);
            else unpad_phase = PH_TYPE;
          end else if (int'(modulus_reg) != int'(bl) + 1 || b != BYTE_TYPE) begin
            flag_error(ST_TYPE);
          end else begin
            unpad_phase = PH_PAD;
          end
        end
        PH_TYPE: begin
          if (modulus_reg != bl || b != BYTE_TYPE) flag_error(ST_TYPE);
          else unpad_phase = PH_PAD;
        end
        PH_PAD: begin
          if (b == BYTE_PAD) begin
            if (unpad_pads < CNT_MAX) unpad_pads++;
          end else if (b == BYTE_ZERO) begin
            rest = (int'(bl) > idx + 1) ? int'(bl) - idx - 1 : 0;
            if (unpad_pads < MIN_PAD) flag_error(ST_SHORTPAD);
            else if (rest > int'(capacity_reg)) flag_error(ST_TOOLARGE);
            else unpad_phase = PH_PAYLOAD;
          end else begin
            flag_error(ST_BADPAD);
          end
        end
        PH_PAYLOAD: begin
          if (unpad_emitted >= capacity_reg) begin
            flag_error(ST_TOOLARGE);
          end else begin
            emit         = 1'b1;
            w.out_byte   = b;
            w.byte_valid = 1'b1;
            if (unpad_emitted < CNT_MAX) unpad_emitted++;
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      if (unpad_phase == PH_TYPE || unpad_phase == PH_FIRST) flag_error(ST_TYPE);
      else if (unpad_phase == PH_PAD) flag_error(ST_NOSEP);
      w.done_res    = 1'b1;
      w.status      = unpad_err;
      w.payload_len = (unpad_err == ST_OK) ? unpad_emitted : '0;
      clear_block();
      words_due.push_back(w);
    end else begin
      if (unpad_index < CNT_MAX) unpad_index++;
      if (emit) words_due.push_back(w);
    end
  endtask

  task automatic check_word();
    unpad_word_t got;
    unpad_word_t want;
    got.out_byte    = res_if.out_byte;
    got.byte_valid  = res_if.byte_valid;
    got.done_res    = res_if.done_res;
    got.status      = status_t'(res_if.status);
    got.payload_len = res_if.payload_len;
    if (words_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte=%h bv=%b done=%b st=%0d len=%0d",
                                got.out_byte, got.byte_valid, got.done_res, got.status,
                                got.payload_len));
    end else begin
      want = words_due.pop_front();
      if (got !== want)
        report_mismatch($sformatf("byte=%h/%h bv=%b/%b done=%b/%b st=%0d/%0d len=%0d/%0d",
                                  got.out_byte, want.out_byte, got.byte_valid,
                                  want.byte_valid, got.done_res, want.done_res, got.status,
                                  want.status, got.payload_len, want.payload_len));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) check_word();
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("pkcs1_type1_pad_checker_tb: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] bl,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.block_len <= bl;
    byte_if.last_byte <= last;
    do @(posedge clk); while (!byte_if.ready);
    advance_unpad_state(b, bl, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f, input logic [LEN_W-1:0] bl);
    foreach (f[i]) send_byte(f[i], bl, i == f.size() - 1);
  endtask

  function automatic frame_t good_frame(input bit lead, input int pads, input int payload);
    frame_t f;
    if (lead) f.push_back(BYTE_ZERO);
    f.push_back(BYTE_TYPE);
    repeat (pads) f.push_back(BYTE_PAD);
    f.push_back(BYTE_ZERO);
    repeat (payload) f.push_back(8'($urandom_range(255)));
    return f;
  endfunction

  task automatic wait_quiet();
    byte_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    wait_quiet();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_MODULUS_LEN) modulus_reg = val;
    else if (idx == REG_OUT_CAPACITY) capacity_reg = val;
  endtask

  task automatic set_config(input logic [LEN_W-1:0] m, input logic [LEN_W-1:0] c);
    write_reg(REG_MODULUS_LEN, m);
    write_reg(REG_OUT_CAPACITY, c);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 73; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 73; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // modulus 256, capacity 512 out of reset
  task automatic test_reset_config();
    send_frame(good_frame(1'b1, 8, 20), 10'd256);
  endtask

  task automatic test_key_small();
    set_config(10'd10, 10'd512);
    send_frame(good_frame(1'b1, 8, 0), 10'd11);
    set_config(10'd0, 10'd512);
    send_frame('{8'h00}, 10'd1);
  endtask

  task automatic test_framing();
    frame_t f;
    set_config(MIN_MODULUS, 10'd512);
    send_frame(good_frame(1'b1, 8, 0), 10'd11);
    send_frame(good_frame(1'b0, 8, 0), 10'd10);
    send_frame(good_frame(1'b0, 8, 1), 10'd11);
    f = good_frame(1'b1, 8, 0);
    f[1] = 8'h02;
    send_frame(f, 10'd11);
    send_frame(good_frame(1'b0, 8, 0), 10'd9);
    f = good_frame(1'b1, 8, 0);
    f[5] = 8'hfe;
    send_frame(f, 10'd11);
    send_frame(good_frame(1'b1, 7, 1), 10'd11);
    f = good_frame(1'b1, 8, 0);
    void'(f.pop_back());
    send_frame(f, 10'd11);
    send_frame('{8'h00}, 10'd11);
    send_frame('{8'h01}, 10'd1);
  endtask

  task automatic test_capacity();
    frame_t f;
    set_config(10'd20, 10'd0);
    send_frame(good_frame(1'b0, 17, 0), 10'd19);
    send_frame(good_frame(1'b0, 16, 1), 10'd19);
    write_reg(REG_OUT_CAPACITY, 10'd3);
    send_frame(good_frame(1'b0, 14, 3), 10'd19);
    send_frame(good_frame(1'b0, 13, 4), 10'd19);
    // more payload than announced
    f = good_frame(1'b0, 14, 5);
    send_frame(f, 10'd19);
  endtask

  task automatic test_block_limit();
    set_config(10'd512, 10'd512);
    // two bytes past the block limit
    send_frame(good_frame(1'b1, 8, 503), 10'd512);
  endtask

  task automatic send_random_block();
    frame_t           f;
    int               lead;
    int               len;
    int               room;
    int               payload;
    int               pick;
    int               k;
    logic [LEN_W-1:0] bl;
    pick = $urandom_range(99);
    if (modulus_reg < MIN_MODULUS || pick < 15) begin
      len = $urandom_range(12, 1);
      repeat (len) f.push_back(8'($urandom_range(255)));
      case ($urandom_range(2))
        0: f[0] = BYTE_ZERO;
        1: f[0] = BYTE_TYPE;
        default: ;
      endcase
      bl = 10'($urandom_range(512, 1));
    end else begin
      lead    = $urandom_range(1);
      len     = int'(modulus_reg) - 1 + lead;
      room    = len - lead - 2;
      payload = $urandom_range((room - 8 < int'(capacity_reg) + 1) ?
                               room - 8 : int'(capacity_reg) + 1, 0);
      f       = good_frame(lead[0], room - payload, payload);
      bl      = 10'(len);
      if (pick >= 75) begin
        k = $urandom_range(room - payload + lead + 1, 0);
        case ($urandom_range(4))
          0: f[k] = 8'($urandom_range(255));
          1: while (f.size() > k + 1) void'(f.pop_back());
          2: repeat ($urandom_range(4, 1)) f.push_back(8'($urandom_range(255)));
          3: bl = (bl == 10'd512 || $urandom_range(1) == 0) ? bl - 10'd1 : bl + 10'd1;
          default: f.delete(lead + 1);
        endcase
      end
    end
    send_frame(f, bl);
  endtask

  task automatic test_random_blocks();
    int               ph;
    int               start;
    logic [LEN_W-1:0] m;
    logic [LEN_W-1:0] c;
    for (ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      case (ph)
        0: begin m = MIN_MODULUS; c = 10'd0; end
        3: begin m = 10'($urandom_range(64, 41)); c = 10'($urandom_range(30)); end
        5: begin m = 10'($urandom_range(40, 11)); c = 10'd512; end
        6: begin m = 10'($urandom_range(10)); c = 10'($urandom_range(32)); end
        default: begin m = 10'($urandom_range(40, 11)); c = 10'($urandom_range(32)); end
      endcase
      set_config(m, c);
      start = bytes_sent;
      while (bytes_sent - start < ((ph == 6) ? 30 : 70)) send_random_block();
    end
  endtask

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.block_len = '0;
    byte_if.last_byte = 1'b0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.wdata      = '0;
    modulus_reg       = MODULUS_RST;
    capacity_reg      = CAPACITY_RST;
    clear_block();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0);
    test_reset_config();
    set_idling(3);
    test_key_small();
    test_framing();
    set_idling(2);
    test_capacity();
    set_idling(1);
    test_block_limit();
    test_random_blocks();

    byte_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("pkcs1_type1_pad_checker_tb: PASS");
    end else begin
      $display("pkcs1_type1_pad_checker_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pcc_pkg.sv
rtl/pcc_byte_if.sv
rtl/pcc_res_if.sv
rtl/pcc_cfg_if.sv
rtl/pkcs1_type1_pad_checker.sv
verif/pkcs1_type1_pad_checker_tb.sv
